@@ rtl/core/fpr_pkg.sv @@
// Shared types, constants and the CRC function of the framed packet receiver.
`default_nettype none

package fpr_pkg;

  // Longest payload taken as a frame; longer frames are drained.
  localparam int unsigned MaxPayload = 64;
  // Entries in the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam logic [15:0] CrcPoly    = 16'h1021;

  localparam logic ReplyAck  = 1'b0;
  localparam logic ReplyNack = 1'b1;

  typedef enum logic [2:0] {
    CFG_START_BYTE      = 3'd0,
    CFG_QUERY_TYPE      = 3'd1,
    CFG_BOOT_COMMAND    = 3'd2,
    CFG_CRC_INITIAL     = 3'd3,
    CFG_HEADER_TIMEOUT  = 3'd4,
    CFG_PAYLOAD_TIMEOUT = 3'd5,
    CFG_DRAIN_TIMEOUT   = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_TYPE    = 4'd1,
    PH_SEQ     = 4'd2,
    PH_LENL    = 4'd3,
    PH_LENH    = 4'd4,
    PH_PAYLOAD = 4'd5,
    PH_CRCL    = 4'd6,
    PH_CRCH    = 4'd7,
    PH_DRAIN   = 4'd8
  } phase_e;

  // One classified request as it travels through the queue.
  typedef struct packed {
    logic       is_tick;
    logic       start_hit;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  query_type;
    logic [7:0]  boot_command;
    logic [15:0] crc_initial;
    logic [15:0] header_timeout;
    logic [15:0] payload_timeout;
    logic [15:0] drain_timeout;
  } cfg_t;

  // CRC16-CCITT, MSB first, one byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/fpr_front.sv @@
// Input side: takes requests and classifies them for the frame engine.
`default_nettype none

module fpr_front
  import fpr_pkg::*;
(
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       op_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic [7:0] start_byte_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output item_t           item_o
);

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.is_tick   = op_i;
    item_o.data      = rx_byte_i;
    // start marker only counts on a byte, not on a tick
    item_o.start_hit = !op_i && (rx_byte_i == start_byte_i);
  end

endmodule

`default_nettype wire

@@ rtl/core/fpr_queue.sv @@
// Small register FIFO between the front and the frame engine.
`default_nettype none

module fpr_queue #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [Width-1:0] rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fpr_back.sv @@
// Frame engine: phase machine, on-the-fly CRC, timeouts and reply register.
`default_nettype none

module fpr_back
  import fpr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire item_t      q_item_i,
  output logic            q_pop_o,
  input  wire cfg_t       cfg_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            reply_kind_o,
  output logic [7:0]      reply_seq_o,
  output logic            boot_request_o
);

  localparam logic [15:0] MaxLen = 16'(MaxPayload);

  phase_e      phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] length_q, length_d;
  logic [16:0] count_q, count_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [7:0]  first_q, first_d;
  logic [15:0] ticks_q, ticks_d;
  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d;
  logic [7:0]  rseq_q, rseq_d;
  logic        boot_q, boot_d;

  logic [15:0] crc_next;
  logic [15:0] timeout;
  logic [15:0] ticks_inc;
  logic [16:0] count_inc;
  logic [15:0] new_len;
  logic        pop;

  // a new request is taken whenever the reply slot is free or being emptied
  assign pop     = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = pop;

  assign crc_next  = crc16_byte(crc_q, q_item_i.data);
  assign ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
  assign count_inc = count_q + 17'd1;
  assign new_len   = {q_item_i.data, len_lo_q};

  always_comb begin
    case (phase_q)
      PH_PAYLOAD: timeout = cfg_i.payload_timeout;
      PH_DRAIN:   timeout = cfg_i.drain_timeout;
      default:    timeout = cfg_i.header_timeout;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    seq_d       = seq_q;
    len_lo_d    = len_lo_q;
    length_d    = length_q;
    count_d     = count_q;
    crc_d       = crc_q;
    crc_lo_d    = crc_lo_q;
    first_d     = first_q;
    ticks_d     = ticks_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    rseq_d      = rseq_q;
    boot_d      = boot_q;

    if (pop) begin
      if (q_item_i.is_tick) begin
        if (phase_q != PH_HUNT) begin
          if (ticks_inc >= timeout) begin
            phase_d = PH_HUNT;
            ticks_d = '0;
          end else begin
            ticks_d = ticks_inc;
          end
        end
      end else begin
        ticks_d = '0;
        case (phase_q)
          PH_TYPE: begin
            type_d  = q_item_i.data;
            crc_d   = crc_next;
            phase_d = PH_SEQ;
          end
          PH_SEQ: begin
            seq_d   = q_item_i.data;
            crc_d   = crc_next;
            phase_d = PH_LENL;
          end
          PH_LENL: begin
            len_lo_d = q_item_i.data;
            crc_d    = crc_next;
            phase_d  = PH_LENH;
          end
          PH_LENH: begin
            length_d = new_len;
            crc_d    = crc_next;
            count_d  = '0;
            first_d  = '0;
            if (new_len > MaxLen) begin
              phase_d = PH_DRAIN;
            end else if (new_len == '0) begin
              phase_d = PH_CRCL;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            if (count_q == '0) begin
              first_d = q_item_i.data;
            end
            crc_d   = crc_next;
            count_d = count_inc;
            if (count_inc >= {1'b0, length_q}) begin
              phase_d = PH_CRCL;
            end
          end
          PH_CRCL: begin
            crc_lo_d = q_item_i.data;
            phase_d  = PH_CRCH;
          end
          PH_CRCH: begin
            phase_d     = PH_HUNT;
            out_valid_d = 1'b1;
            rseq_d      = seq_q;
            kind_d      = ReplyNack;
            boot_d      = 1'b0;
            if ({q_item_i.data, crc_lo_q} == crc_q && type_q == cfg_i.query_type &&
                length_q == 16'd1) begin
              kind_d = ReplyAck;
              boot_d = (first_q == cfg_i.boot_command);
            end
          end
          PH_DRAIN: begin
            count_d = count_inc;
            if (count_inc >= {1'b0, length_q} + 17'd2) begin
              phase_d = PH_HUNT;
            end
          end
          default: begin
            phase_d = PH_HUNT;
            if (q_item_i.start_hit) begin
              crc_d   = crc16_byte(cfg_i.crc_initial, q_item_i.data);
              phase_d = PH_TYPE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      ticks_q     <= ticks_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q   <= type_d;
    seq_q    <= seq_d;
    len_lo_q <= len_lo_d;
    length_q <= length_d;
    count_q  <= count_d;
    crc_q    <= crc_d;
    crc_lo_q <= crc_lo_d;
    first_q  <= first_d;
    kind_q   <= kind_d;
    rseq_q   <= rseq_d;
    boot_q   <= boot_d;
  end

  assign out_valid_o    = out_valid_q;
  assign reply_kind_o   = kind_q;
  assign reply_seq_o    = rseq_q;
  assign boot_request_o = boot_q;

`ifndef SYNTH
  a_crch_replies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !q_item_i.is_tick && phase_q == PH_CRCH) |=> (out_valid_q && phase_q == PH_HUNT))
    else $error("closing CRC byte did not load a reply");
  a_boot_only_on_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && boot_q) |-> (kind_q == ReplyAck))
    else $error("boot request flagged on a NACK");
  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (count_q < {1'b0, length_q}))
    else $error("payload count ran past frame length");
`endif

endmodule

`default_nettype wire

@@ rtl/core/framed_packet_receiver_crc16_ack.sv @@
// Top level: out_valid_o rises once the closing CRC byte has passed the queue and the
// reply register, with the queue ahead empty and the reply slot free; a waiting reply
// adds its stall. Throughput one request per cycle while no reply waits; a 2-entry queue
// takes up to two more while a reply waits; the phase machine retires one per cycle.
// Reset: phase returns to hunting, queue and reply slot empty, registers to
// their defaults (start 2, query 81, boot 1, CRC init FFFF, timeouts 50/200/10).
`default_nettype none

module framed_packet_receiver_crc16_ack
  import fpr_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             reply_kind_o,
  output logic [7:0]       reply_seq_o,
  output logic             boot_request_o
);

  cfg_t  cfg_q, cfg_d;
  item_t push_item;
  item_t head_item;
  logic  push, q_full, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_START_BYTE:      cfg_d.start_byte      = cfg_data_i[7:0];
        CFG_QUERY_TYPE:      cfg_d.query_type      = cfg_data_i[7:0];
        CFG_BOOT_COMMAND:    cfg_d.boot_command    = cfg_data_i[7:0];
        CFG_CRC_INITIAL:     cfg_d.crc_initial     = cfg_data_i;
        CFG_HEADER_TIMEOUT:  cfg_d.header_timeout  = cfg_data_i;
        CFG_PAYLOAD_TIMEOUT: cfg_d.payload_timeout = cfg_data_i;
        CFG_DRAIN_TIMEOUT:   cfg_d.drain_timeout   = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte      <= 8'd2;
      cfg_q.query_type      <= 8'd81;
      cfg_q.boot_command    <= 8'd1;
      cfg_q.crc_initial     <= 16'hFFFF;
      cfg_q.header_timeout  <= 16'd50;
      cfg_q.payload_timeout <= 16'd200;
      cfg_q.drain_timeout   <= 16'd10;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fpr_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .rx_byte_i    (rx_byte_i),
    .start_byte_i (cfg_q.start_byte),
    .q_full_i     (q_full),
    .push_o       (push),
    .item_o       (push_item)
  );

  fpr_queue #(
    .Width ($bits(item_t)),
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (head_item)
  );

  fpr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (head_item),
    .q_pop_o        (q_pop),
    .cfg_i          (cfg_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .reply_kind_o   (reply_kind_o),
    .reply_seq_o    (reply_seq_o),
    .boot_request_o (boot_request_o)
  );

endmodule

`default_nettype wire
